[hw/rtl/usk_pkg.sv]
// usk_pkg: shared types, constants and folding functions for the UTF-8 search-key folder.
// Used by usk_front, usk_queue, usk_back and utf8_search_key_folder_top.
package usk_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CP_W        = 21;
    localparam int CHAR_W      = 7;
    localparam int GREEK_W     = 5;
    localparam int POS_W       = 3;
    localparam int GREEK_COUNT = 24;

    // Code point landmarks
    localparam logic [CP_W-1:0] ASCII_END       = 21'h000080;
    localparam logic [CP_W-1:0] GREEK_LO_FIRST  = 21'h0003B1;
    localparam logic [CP_W-1:0] GREEK_LO_LAST   = 21'h0003C9;
    localparam logic [CP_W-1:0] FINAL_SIGMA     = 21'h0003C2;
    localparam logic [CP_W-1:0] GREEK_UP_FIRST  = 21'h000391;
    localparam logic [CP_W-1:0] GREEK_UP_LAST   = 21'h0003A9;
    localparam logic [CP_W-1:0] GREEK_UP_GAP    = 21'h0003A2;
    localparam logic [CP_W-1:0] SUP_ONE         = 21'h0000B9;
    localparam logic [CP_W-1:0] SUP_TWO         = 21'h0000B2;
    localparam logic [CP_W-1:0] SUP_THREE       = 21'h0000B3;
    localparam logic [CP_W-1:0] SUPER_FIRST     = 21'h002070;
    localparam logic [CP_W-1:0] SUPER_LAST      = 21'h002079;
    localparam logic [CP_W-1:0] LATIN_UP_FIRST  = 21'h0000C0;
    localparam logic [CP_W-1:0] LATIN_UP_LAST   = 21'h0000DE;
    localparam logic [CP_W-1:0] EXT_A_FIRST     = 21'h000100;
    localparam logic [CP_W-1:0] EXT_A_END       = 21'h000180;

    localparam logic [GREEK_W-1:0] SIGMA_IDX = 5'd18;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_0 = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_1 = 7'h31;
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_2 = 7'h32;
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_3 = 7'h33;
    localparam logic [CHAR_W-1:0] ASCII_DIGIT_9 = 7'h39;
    localparam logic [CHAR_W-1:0] ASCII_UP_A    = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_UP_Z    = 7'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LO_A    = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_LO_Z    = 7'h7A;
    localparam logic [CHAR_W-1:0] ASCII_CASE    = 7'h20;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } usk_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] key_char;
        logic              char_present;
        logic              run_last;
        logic              key_end;
    } usk_out_t;

    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_CHAR,
        TOK_GREEK
    } usk_tok_kind_t;

    // One folded code point: a single character or a Greek letter index (1..24)
    typedef struct packed {
        usk_tok_kind_t     kind;
        logic [CHAR_W-1:0] val;
    } usk_tok_t;

    // Work for one input byte: up to two folded code points, end-of-key flag
    typedef struct packed {
        usk_tok_t tok0;
        usk_tok_t tok1;
        logic     fin;
    } usk_job_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } usk_q_stat_t;

    localparam logic [63:0] GREEK_NAME [GREEK_COUNT] = '{
        "alpha", "beta", "gamma", "delta", "epsilon", "zeta", "eta", "theta",
        "iota", "kappa", "lambda", "mu", "nu", "xi", "omicron", "pi",
        "rho", "sigma", "tau", "upsilon", "phi", "chi", "psi", "omega"};

    localparam logic [POS_W-1:0] GREEK_LEN [GREEK_COUNT] = '{
        3'd5, 3'd4, 3'd5, 3'd5, 3'd7, 3'd4, 3'd3, 3'd5,
        3'd4, 3'd5, 3'd6, 3'd2, 3'd2, 3'd2, 3'd7, 3'd2,
        3'd3, 3'd5, 3'd3, 3'd7, 3'd3, 3'd3, 3'd3, 3'd5};

    function automatic logic [POS_W-1:0] greek_len(input logic [GREEK_W-1:0] idx);
        logic [POS_W-1:0] len;
        if (idx == '0 || idx > GREEK_W'(GREEK_COUNT)) begin
            len = 3'd1;
        end
        else begin
            len = GREEK_LEN[idx - 5'd1];
        end
        return len;
    endfunction

    // Character at position pos of the spelled-out name; names sit right-justified
    function automatic logic [CHAR_W-1:0] greek_char(input logic [GREEK_W-1:0] idx,
                                                     input logic [POS_W-1:0]   pos);
        logic [63:0]      name;
        logic [POS_W-1:0] sel;
        if (idx == '0 || idx > GREEK_W'(GREEK_COUNT)) begin
            name = '0;
        end
        else begin
            name = GREEK_NAME[idx - 5'd1];
        end
        sel = greek_len(idx) - 3'd1 - pos;
        return name[{sel, 3'b000} +: CHAR_W];
    endfunction

    // Latin-1 / Extended-A lowercase letter with diacritic to base letter: {hit, char}
    function automatic logic [CHAR_W:0] latin_base(input logic [8:0] low);
        logic [CHAR_W:0] res;
        unique case (low)
            9'h0E0, 9'h0E1, 9'h0E2, 9'h0E3, 9'h0E4, 9'h0E5,
            9'h101, 9'h103:                                  res = {1'b1, 7'h61}; // a
            9'h0E7:                                          res = {1'b1, 7'h63}; // c
            9'h0E8, 9'h0E9, 9'h0EA, 9'h0EB, 9'h113:          res = {1'b1, 7'h65}; // e
            9'h11F:                                          res = {1'b1, 7'h67}; // g
            9'h0EC, 9'h0ED, 9'h0EE, 9'h0EF, 9'h12B:          res = {1'b1, 7'h69}; // i
            9'h0F1:                                          res = {1'b1, 7'h6E}; // n
            9'h0F2, 9'h0F3, 9'h0F4, 9'h0F5, 9'h0F6, 9'h0F8,
            9'h14D:                                          res = {1'b1, 7'h6F}; // o
            9'h15F, 9'h161:                                  res = {1'b1, 7'h73}; // s
            9'h0F9, 9'h0FA, 9'h0FB, 9'h0FC, 9'h16B:          res = {1'b1, 7'h75}; // u
            9'h0FD, 9'h0FF:                                  res = {1'b1, 7'h79}; // y
            9'h17E:                                          res = {1'b1, 7'h7A}; // z
            default:                                         res = '0;
        endcase
        return res;
    endfunction

    function automatic usk_tok_t fold_cp(input logic [CP_W-1:0] cp);
        usk_tok_t          tok;
        logic [CP_W-1:0]   diff;
        logic [8:0]        low;
        logic [CHAR_W:0]   base;
        tok.kind = TOK_NONE;
        tok.val  = '0;
        diff     = '0;
        low      = '0;
        base     = '0;
        if (cp < ASCII_END) begin
            if ((cp[6:0] >= ASCII_DIGIT_0 && cp[6:0] <= ASCII_DIGIT_9) ||
                (cp[6:0] >= ASCII_LO_A && cp[6:0] <= ASCII_LO_Z)) begin
                tok.kind = TOK_CHAR;
                tok.val  = cp[6:0];
            end
            else if (cp[6:0] >= ASCII_UP_A && cp[6:0] <= ASCII_UP_Z) begin
                tok.kind = TOK_CHAR;
                tok.val  = cp[6:0] + ASCII_CASE;
            end
        end
        else if (cp >= GREEK_LO_FIRST && cp <= GREEK_LO_LAST) begin
            tok.kind = TOK_GREEK;
            if (cp == FINAL_SIGMA) begin
                tok.val = {2'b00, SIGMA_IDX};
            end
            else begin
                diff    = cp - GREEK_LO_FIRST;
                tok.val = {2'b00, diff[4:0]} + ((cp > FINAL_SIGMA) ? 7'd0 : 7'd1);
            end
        end
        else if (cp >= GREEK_UP_FIRST && cp <= GREEK_UP_LAST && cp != GREEK_UP_GAP) begin
            tok.kind = TOK_GREEK;
            diff     = cp - GREEK_UP_FIRST;
            tok.val  = {2'b00, diff[4:0]} + ((cp > GREEK_UP_GAP) ? 7'd0 : 7'd1);
        end
        else if (cp == SUP_ONE) begin
            tok.kind = TOK_CHAR;
            tok.val  = ASCII_DIGIT_1;
        end
        else if (cp == SUP_TWO) begin
            tok.kind = TOK_CHAR;
            tok.val  = ASCII_DIGIT_2;
        end
        else if (cp == SUP_THREE) begin
            tok.kind = TOK_CHAR;
            tok.val  = ASCII_DIGIT_3;
        end
        else if (cp >= SUPER_FIRST && cp <= SUPER_LAST) begin
            tok.kind = TOK_CHAR;
            tok.val  = ASCII_DIGIT_0 + {3'd0, cp[3:0]};
        end
        else if (cp < EXT_A_END) begin
            low = cp[8:0];
            if (cp >= LATIN_UP_FIRST && cp <= LATIN_UP_LAST) begin
                low = cp[8:0] + 9'h020;
            end
            else if (cp >= EXT_A_FIRST && !cp[0]) begin
                low = cp[8:0] | 9'h001;
            end
            base = latin_base(low);
            if (base[CHAR_W]) begin
                tok.kind = TOK_CHAR;
                tok.val  = base[CHAR_W-1:0];
            end
        end
        return tok;
    endfunction

endpackage

[hw/rtl/usk_front.sv]
// usk_front: UTF-8 decoder and folder; each final byte, or byte yielding a character, becomes a queue job.
// Depends on usk_pkg.
module usk_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  usk_pkg::usk_in_t  in_data,
    output logic              push,
    output usk_pkg::usk_job_t job
);

    logic [7:0] held_reg  [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] bytes_needed_reg, bytes_needed_next;
    logic [1:0] seq_count, seq_needed;

    logic [7:0]               b;
    logic                     lead_ok;
    logic [1:0]               lead_n;
    logic [usk_pkg::CP_W-1:0] main_cp, cp_seq, cp_a, cp_b;
    logic                     main_on, a_on, b_on;
    logic                     tail_on, t0_ascii, t0_two, t1_ascii;
    logic [7:0]               t0, t1;
    usk_pkg::usk_tok_t        tok_a, tok_b, tok_none;

    assign b = in_data.text_byte;

    // Lead byte classification: continuation count, or not a lead at all
    always_comb
    begin
        lead_ok = 1'b1;
        lead_n  = 2'd0;
        if (!b[7]) begin
            lead_n = 2'd0;
        end
        else if (b[7:5] == 3'b110) begin
            lead_n = 2'd1;
        end
        else if (b[7:4] == 4'b1110) begin
            lead_n = 2'd2;
        end
        else if (b[7:3] == 5'b11110) begin
            lead_n = 2'd3;
        end
        else begin
            lead_ok = 1'b0;
        end
    end

    always_comb
    begin
        unique case (held_count_reg)
            2'd1:    main_cp = {10'd0, held_reg[0][4:0], b[5:0]};
            2'd2:    main_cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], b[5:0]};
            2'd3:    main_cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], b[5:0]};
            default: main_cp = '0;
        endcase
    end

    // Sequence state after this byte, before the end-of-string flush
    always_comb
    begin
        held_next    = held_reg;
        seq_count    = 2'd0;
        seq_needed   = 2'd0;
        main_on      = 1'b0;
        cp_seq       = main_cp;
        if (bytes_needed_reg != 2'd0 && held_count_reg != 2'd0) begin
            if (bytes_needed_reg == 2'd1) begin
                main_on = 1'b1;
            end
            else if (held_count_reg != 2'd3) begin
                held_next[held_count_reg] = b;
                seq_count  = held_count_reg + 2'd1;
                seq_needed = bytes_needed_reg - 2'd1;
            end
        end
        else if (lead_ok && lead_n == 2'd0) begin
            main_on = 1'b1;
            cp_seq  = {13'd0, b};
        end
        else if (lead_ok) begin
            held_next[0] = b;
            seq_count    = 2'd1;
            seq_needed   = lead_n;
        end
    end

    // End of string with a sequence still open: drop the lead, decode the rest
    assign t0       = held_next[1];
    assign t1       = held_next[2];
    assign t0_ascii = !t0[7];
    assign t0_two   = (t0[7:5] == 3'b110);
    assign t1_ascii = !t1[7];
    assign tail_on  = in_data.final_byte && seq_needed != 2'd0 && seq_count != 2'd0;

    always_comb
    begin
        a_on = main_on;
        cp_a = cp_seq;
        cp_b = {13'd0, t1};
        b_on = tail_on && seq_count == 2'd3 && t1_ascii && !t0_two;
        if (!main_on) begin
            cp_a = {13'd0, t0};
            if (tail_on && seq_count >= 2'd2 && t0_ascii) begin
                a_on = 1'b1;
            end
            else if (tail_on && seq_count == 2'd3 && t0_two) begin
                a_on = 1'b1;
                cp_a = {10'd0, t0[4:0], t1[5:0]};
            end
        end
    end

    always_comb
    begin
        tok_none.kind = usk_pkg::TOK_NONE;
        tok_none.val  = '0;
        tok_a = a_on ? usk_pkg::fold_cp(cp_a) : tok_none;
        tok_b = b_on ? usk_pkg::fold_cp(cp_b) : tok_none;
        // Compact so the first slot holds a character whenever there is one
        if (tok_a.kind == usk_pkg::TOK_NONE) begin
            job.tok0 = tok_b;
            job.tok1 = tok_none;
        end
        else begin
            job.tok0 = tok_a;
            job.tok1 = tok_b;
        end
        job.fin = in_data.final_byte;
        push    = accept && (job.tok0.kind != usk_pkg::TOK_NONE || in_data.final_byte);
    end

    assign held_count_next   = in_data.final_byte ? 2'd0 : seq_count;
    assign bytes_needed_next = in_data.final_byte ? 2'd0 : seq_needed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_count_reg   <= 2'd0;
            bytes_needed_reg <= 2'd0;
        end
        else if (accept) begin
            held_count_reg   <= held_count_next;
            bytes_needed_reg <= bytes_needed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

[hw/rtl/usk_queue.sv]
// usk_queue: small job queue between the decoder front and the expander back.
// Depends on usk_pkg.
module usk_queue #(
    parameter int DEPTH = usk_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  usk_pkg::usk_job_t    push_job,
    input  logic                 pop,
    output usk_pkg::usk_job_t    head_job,
    output usk_pkg::usk_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usk_pkg::usk_job_t slot_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.head_valid = (count_reg != '0);
    assign head_job        = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/usk_back.sv]
// usk_back: expands queued jobs into key characters, one beat per cycle unless stalled, into an output register.
// Depends on usk_pkg.
module usk_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  usk_pkg::usk_job_t    head_job,
    input  usk_pkg::usk_q_stat_t q_stat,
    output logic                 pop,
    output logic                 key_valid,
    input  logic                 key_ready,
    output usk_pkg::usk_out_t    key_data
);

    logic [usk_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      slot_reg, slot_next;
    logic                      out_valid_reg, out_valid_next;
    usk_pkg::usk_out_t         out_data_reg, out_data_next;

    usk_pkg::usk_tok_t         cur_tok;
    logic [usk_pkg::POS_W-1:0] tok_len;
    logic                      tok_done, marker, job_done, emit;

    assign cur_tok  = slot_reg ? head_job.tok1 : head_job.tok0;
    assign tok_len  = (cur_tok.kind == usk_pkg::TOK_GREEK) ?
                      usk_pkg::greek_len(cur_tok.val[usk_pkg::GREEK_W-1:0]) : 3'd1;
    assign tok_done = (pos_reg == tok_len - 3'd1);
    assign marker   = (head_job.tok0.kind == usk_pkg::TOK_NONE);
    assign job_done = marker ||
                      (tok_done && (slot_reg || head_job.tok1.kind == usk_pkg::TOK_NONE));
    assign emit     = q_stat.head_valid && (!out_valid_reg || key_ready);
    assign pop      = emit && job_done;

    always_comb
    begin
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !key_ready;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            unique case (cur_tok.kind)
                usk_pkg::TOK_CHAR:  out_data_next.key_char = cur_tok.val;
                usk_pkg::TOK_GREEK: out_data_next.key_char =
                    usk_pkg::greek_char(cur_tok.val[usk_pkg::GREEK_W-1:0], pos_reg);
                default:            out_data_next.key_char = '0;
            endcase
            out_data_next.char_present = !marker;
            out_data_next.run_last     = job_done;
            out_data_next.key_end      = job_done && head_job.fin;
            // Advance through the letters, then the second slot, then drop the job
            if (job_done) begin
                pos_next  = '0;
                slot_next = 1'b0;
            end
            else if (tok_done) begin
                pos_next  = '0;
                slot_next = 1'b1;
            end
            else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            slot_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign key_valid = out_valid_reg;
    assign key_data  = out_data_reg;

endmodule

[hw/rtl/utf8_search_key_folder_top.sv]
// UTF-8 search-key folder, top level: decoder front, job queue, character expander back.
// Depends on usk_pkg, usk_front, usk_queue and usk_back.
//
// Usage:
//   src channel (src_valid / src_ready / src_data): one beat per string byte, with
//   final_byte set on the last byte of the string.
//   key channel (key_valid / key_ready / key_data): one beat per key character, a
//   lowercase letter or digit. run_last closes the beats caused by one input byte;
//   key_end closes the whole key. A string whose last byte yields nothing closes
//   with one bare marker beat (char_present low).
//   An accepted byte's job is written to the queue; its first key beat is then held
//   in the output register. Throughput: one byte per cycle while each byte yields at
//   most one character and key_ready is high. A Greek letter spells out to 2..7
//   beats, one per cycle from the back end while key_ready is high; the job queue
//   (QUEUE_DEPTH jobs) keeps taking bytes meanwhile and src_ready drops only once it is full.
//   Stall: when key_ready is low the output register holds its beat, the back end
//   stops draining the queue, and the front keeps accepting until the queue fills.
//   Reset (rst_n low, asynchronous): drops any partial sequence, empties the queue
//   and clears the output valid flag; src_ready is already high while rst_n is low.
module utf8_search_key_folder_top #(
    parameter int QUEUE_DEPTH = usk_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_ready,
    input  usk_pkg::usk_in_t  src_data,
    output logic              key_valid,
    input  logic              key_ready,
    output usk_pkg::usk_out_t key_data
);

    logic                 src_accept;
    logic                 q_push;
    logic                 q_pop;
    usk_pkg::usk_job_t    q_in_job;
    usk_pkg::usk_job_t    q_head_job;
    usk_pkg::usk_q_stat_t q_stat;

    // Take a byte whenever the queue has room for its job
    assign src_ready  = !q_stat.full;
    assign src_accept = src_valid && src_ready;

    usk_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (src_accept),
        .in_data (src_data),
        .push    (q_push),
        .job     (q_in_job)
    );

    usk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .head_job (q_head_job),
        .stat     (q_stat)
    );

    usk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (q_head_job),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_data  (key_data)
    );

`ifndef SYNTHESIS
    // Every final byte must leave a job, so the key always closes
    a_final_enqueues: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready && src_data.final_byte |-> q_push)
        else $error("final byte accepted without queuing a job");

    // Hold the queue while the receiver stalls a waiting beat
    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_ready |-> !q_pop)
        else $error("job dropped while output stalled");

    // A bare marker only ever closes a key
    a_marker_closes_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_data.char_present |-> key_data.run_last && key_data.key_end)
        else $error("bare marker beat not closing the key");
`endif

endmodule
